// ----- rtl/sxl_pkg.sv -----
// shared types, character codes and class helpers for the s-expression byte lexer
`default_nettype none

package sxl_pkg;

  localparam int unsigned CounterWidthDefault = 16;
  localparam int unsigned QueueDepth          = 4;
  localparam int unsigned QueuePtrWidth       = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth       = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharLparen = 8'h28;
  localparam logic [7:0] CharRparen = 8'h29;
  localparam logic [7:0] CharQuote  = 8'h27;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharNl     = 8'h0a;
  localparam logic [7:0] CharStar   = 8'h2a;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSlash  = 8'h2f;
  localparam logic [7:0] CharUscore = 8'h5f;

  typedef enum logic [2:0] {
    TOK_LPAREN = 3'd0,
    TOK_RPAREN = 3'd1,
    TOK_SYMBOL = 3'd2,
    TOK_NUMBER = 3'd3,
    TOK_STRING = 3'd4,
    TOK_QUOTE  = 3'd5,
    TOK_ERROR  = 3'd6,
    TOK_EOF    = 3'd7
  } tok_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNTERM_STR = 2'd1,
    ERR_UNEXPECTED = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NUMBER = 4'b0010,
    MODE_SYMBOL = 4'b0100,
    MODE_STRING = 4'b1000
  } mode_e;

  // one result as it leaves the block
  typedef struct packed {
    tok_e        token_type;
    logic [7:0]  value_byte;
    logic        has_byte;
    logic        token_start;
    logic        token_end;
    err_e        error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last;
  } res_t;

  // all results of one request, in order
  typedef struct packed {
    logic [1:0] count;
    res_t       slot0;
    res_t       slot1;
  } step_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
  endfunction

  function automatic logic is_symbol_member(logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7a)) ||
           ((b >= 8'h41) && (b <= 8'h5a)) || (b == CharStar) ||
           (b == CharMinus) || (b == CharPlus) || (b == CharSlash) ||
           (b == CharUscore);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sxl_core.sv -----
// lexer mode, line and column state with the per-byte classification logic
`default_nettype none

module sxl_core #(
  parameter int unsigned COUNTER_WIDTH = sxl_pkg::CounterWidthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          action_i,
  input  wire logic [7:0]    byte_value_i,
  output sxl_pkg::step_t     step_o
);

  localparam logic [COUNTER_WIDTH-1:0] CntOne = COUNTER_WIDTH'(1);

  sxl_pkg::mode_e            mode_q, mode_d;
  logic [COUNTER_WIDTH-1:0]  line_q, line_d;
  logic [COUNTER_WIDTH-1:0]  col_q, col_d;
  logic [15:0]               line_sat, col_sat;
  logic [COUNTER_WIDTH-1:0]  col_bump, line_bump;

  logic                      pre_vld, main_vld;
  sxl_pkg::res_t             pre_r, main_r;

  // saturate the reported position to 16 bits
  if (COUNTER_WIDTH > 16) begin : g_sat
    assign line_sat = (|line_q[COUNTER_WIDTH-1:16]) ? 16'hffff : line_q[15:0];
    assign col_sat  = (|col_q[COUNTER_WIDTH-1:16]) ? 16'hffff : col_q[15:0];
  end else begin : g_nosat
    assign line_sat = 16'(line_q);
    assign col_sat  = 16'(col_q);
  end

  assign col_bump  = (&col_q) ? col_q : col_q + CntOne;
  assign line_bump = (&line_q) ? line_q : line_q + CntOne;

  function automatic sxl_pkg::res_t mk(sxl_pkg::tok_e t, logic [7:0] b, logic has,
                                       logic s, logic e, sxl_pkg::err_e err);
    sxl_pkg::res_t r;
    r.token_type    = t;
    r.value_byte    = has ? b : 8'h00;
    r.has_byte      = has;
    r.token_start   = s;
    r.token_end     = e;
    r.error_code    = err;
    r.line_number   = 16'h0000;
    r.column_number = 16'h0000;
    r.last          = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic run_cont;
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    pre_vld  = 1'b0;
    main_vld = 1'b0;
    pre_r    = mk(sxl_pkg::TOK_EOF, 8'h00, 1'b0, 1'b0, 1'b0, sxl_pkg::ERR_NONE);
    main_r   = pre_r;
    run_cont = ((mode_q == sxl_pkg::MODE_NUMBER) && sxl_pkg::is_digit(byte_value_i)) ||
               ((mode_q == sxl_pkg::MODE_SYMBOL) &&
                sxl_pkg::is_symbol_member(byte_value_i));

    if (action_i) begin
      // end of input: close or abandon the open token, then eof
      case (mode_q)
        sxl_pkg::MODE_NUMBER: begin
          pre_vld = 1'b1;
          pre_r   = mk(sxl_pkg::TOK_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, sxl_pkg::ERR_NONE);
        end
        sxl_pkg::MODE_SYMBOL: begin
          pre_vld = 1'b1;
          pre_r   = mk(sxl_pkg::TOK_SYMBOL, 8'h00, 1'b0, 1'b0, 1'b1, sxl_pkg::ERR_NONE);
        end
        sxl_pkg::MODE_STRING: begin
          pre_vld = 1'b1;
          pre_r   = mk(sxl_pkg::TOK_ERROR, 8'h00, 1'b0, 1'b1, 1'b1,
                       sxl_pkg::ERR_UNTERM_STR);
        end
        default: pre_vld = 1'b0;
      endcase
      main_vld = 1'b1;
      main_r   = mk(sxl_pkg::TOK_EOF, 8'h00, 1'b0, 1'b1, 1'b1, sxl_pkg::ERR_NONE);
      mode_d   = sxl_pkg::MODE_IDLE;
      line_d   = CntOne;
      col_d    = CntOne;
    end else if (mode_q == sxl_pkg::MODE_STRING) begin
      col_d    = col_bump;
      main_vld = 1'b1;
      if (byte_value_i == sxl_pkg::CharDquote) begin
        mode_d = sxl_pkg::MODE_IDLE;
        main_r = mk(sxl_pkg::TOK_STRING, 8'h00, 1'b0, 1'b0, 1'b1, sxl_pkg::ERR_NONE);
      end else begin
        main_r = mk(sxl_pkg::TOK_STRING, byte_value_i, 1'b1, 1'b0, 1'b0,
                    sxl_pkg::ERR_NONE);
      end
    end else if (run_cont) begin
      col_d    = col_bump;
      main_vld = 1'b1;
      main_r   = mk((mode_q == sxl_pkg::MODE_NUMBER) ? sxl_pkg::TOK_NUMBER
                                                     : sxl_pkg::TOK_SYMBOL,
                    byte_value_i, 1'b1, 1'b0, 1'b0, sxl_pkg::ERR_NONE);
    end else begin
      // a run closes on a non-member byte, which is then lexed from idle
      if (mode_q == sxl_pkg::MODE_NUMBER) begin
        pre_vld = 1'b1;
        pre_r   = mk(sxl_pkg::TOK_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, sxl_pkg::ERR_NONE);
      end else if (mode_q == sxl_pkg::MODE_SYMBOL) begin
        pre_vld = 1'b1;
        pre_r   = mk(sxl_pkg::TOK_SYMBOL, 8'h00, 1'b0, 1'b0, 1'b1, sxl_pkg::ERR_NONE);
      end
      mode_d = sxl_pkg::MODE_IDLE;
      if (sxl_pkg::is_space(byte_value_i)) begin
        if (byte_value_i == sxl_pkg::CharNl) begin
          line_d = line_bump;
          col_d  = CntOne;
        end else begin
          col_d = col_bump;
        end
      end else begin
        col_d    = col_bump;
        main_vld = 1'b1;
        if (byte_value_i == sxl_pkg::CharLparen) begin
          main_r = mk(sxl_pkg::TOK_LPAREN, byte_value_i, 1'b1, 1'b1, 1'b1,
                      sxl_pkg::ERR_NONE);
        end else if (byte_value_i == sxl_pkg::CharRparen) begin
          main_r = mk(sxl_pkg::TOK_RPAREN, byte_value_i, 1'b1, 1'b1, 1'b1,
                      sxl_pkg::ERR_NONE);
        end else if (byte_value_i == sxl_pkg::CharQuote) begin
          main_r = mk(sxl_pkg::TOK_QUOTE, byte_value_i, 1'b1, 1'b1, 1'b1,
                      sxl_pkg::ERR_NONE);
        end else if (sxl_pkg::is_digit(byte_value_i)) begin
          mode_d = sxl_pkg::MODE_NUMBER;
          main_r = mk(sxl_pkg::TOK_NUMBER, byte_value_i, 1'b1, 1'b1, 1'b0,
                      sxl_pkg::ERR_NONE);
        end else if (byte_value_i == sxl_pkg::CharDquote) begin
          mode_d = sxl_pkg::MODE_STRING;
          main_r = mk(sxl_pkg::TOK_STRING, 8'h00, 1'b0, 1'b1, 1'b0, sxl_pkg::ERR_NONE);
        end else if (sxl_pkg::is_symbol_member(byte_value_i)) begin
          mode_d = sxl_pkg::MODE_SYMBOL;
          main_r = mk(sxl_pkg::TOK_SYMBOL, byte_value_i, 1'b1, 1'b1, 1'b0,
                      sxl_pkg::ERR_NONE);
        end else begin
          main_r = mk(sxl_pkg::TOK_ERROR, byte_value_i, 1'b1, 1'b1, 1'b1,
                      sxl_pkg::ERR_UNEXPECTED);
        end
      end
    end

    pre_r.line_number    = line_sat;
    pre_r.column_number  = col_sat;
    main_r.line_number   = line_sat;
    main_r.column_number = col_sat;
    pre_r.last           = !main_vld;
    main_r.last          = 1'b1;
  end

  // pack results so that slot0 is always the first one
  always_comb begin
    step_o.count = 2'({1'b0, pre_vld} + {1'b0, main_vld});
    step_o.slot0 = pre_vld ? pre_r : main_r;
    step_o.slot1 = main_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sxl_pkg::MODE_IDLE;
      line_q <= CntOne;
      col_q  <= CntOne;
    end else if (accept_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("lexer mode lost its one-hot code");

  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && action_i |=> mode_q == sxl_pkg::MODE_IDLE && line_q == CntOne &&
                             col_q == CntOne)
    else $error("end of input did not return lexer to reset state");

endmodule

`default_nettype wire

// ----- rtl/sexpr_byte_lexer.sv -----
// top level of the streaming s-expression byte lexer
//
// input channel: one request per source byte (action_i = 0) or an end-of-input
// marker (action_i = 1), taken when in_valid_i and in_ready_o are both high
// output channel: one token result per transfer, taken when out_valid_o and
// out_ready_i are both high; a request yields zero, one or two results, and
// last_o marks the final result of each request
// the results of a request are written into a four-entry result queue and
// leave it from its head
// throughput: one request per cycle while the receiver keeps up; a request
// with two results (a run closed by a token byte, or end of input with an
// open token) takes two output transfers, and the input side keeps
// running until the queue is down to fewer than two free entries
// stall: while out_ready_i is low the queue fills; in_ready_o drops as soon as
// a worst-case request (two results) would no longer fit
// reset: the queue empties, the mode returns to idle between tokens and the
// line and column counters go back to one; end of input does the same to
// the mode and counters
`default_nettype none

module sexpr_byte_lexer #(
  parameter int unsigned COUNTER_WIDTH = sxl_pkg::CounterWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  byte_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       token_type_o,
  output logic [7:0]       value_byte_o,
  output logic             has_byte_o,
  output logic             token_start_o,
  output logic             token_end_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      line_number_o,
  output logic [15:0]      column_number_o,
  output logic             last_o
);

  localparam int unsigned Depth = sxl_pkg::QueueDepth;
  localparam int unsigned PtrW  = sxl_pkg::QueuePtrWidth;
  localparam int unsigned CntW  = sxl_pkg::QueueCntWidth;

  sxl_pkg::step_t         step;
  sxl_pkg::res_t          q_mem [Depth];
  sxl_pkg::res_t          head;
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   in_acc, out_acc;

  // request is taken only when two result slots are free
  assign in_ready_o  = (cnt_q <= CntW'(Depth - 2));
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;

  sxl_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .action_i     (action_i),
    .byte_value_i (byte_value_i),
    .step_o       (step)
  );

  // queue pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (in_acc) begin
      wr_ptr_d = wr_ptr_q + PtrW'(step.count);
      cnt_d    = cnt_d + CntW'(step.count);
    end
    if (out_acc) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      cnt_d    = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage, no reset needed on payload
  always_ff @(posedge clk_i) begin
    if (in_acc && (step.count != 2'd0)) begin
      q_mem[wr_ptr_q] <= step.slot0;
    end
    if (in_acc && (step.count == 2'd2)) begin
      q_mem[wr_ptr_q + PtrW'(1)] <= step.slot1;
    end
  end

  assign head            = q_mem[rd_ptr_q];
  assign token_type_o    = head.token_type;
  assign value_byte_o    = head.value_byte;
  assign has_byte_o      = head.has_byte;
  assign token_start_o   = head.token_start;
  assign token_end_o     = head.token_end;
  assign error_code_o    = head.error_code;
  assign line_number_o   = head.line_number;
  assign column_number_o = head.column_number;
  assign last_o          = head.last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> out_valid_o)
    else $error("second result of a request missing from queue");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc && !out_acc |=> $stable(cnt_q))
    else $error("queue fill changed with no transfer");

endmodule

`default_nettype wire
